### rtl/deq_pkg.sv
// deq_pkg: shared constants and types for the double-ended queue unit
// no dependencies; used by the channel interfaces, the cell and the top level

package deq_pkg;

    // store geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int ACT_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    // action codes
    localparam logic [ACT_W-1:0] ACT_READ_ALL   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // what one cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_LEFT,
        CELL_SHIFT_RIGHT,
        CELL_LOAD
    } cell_op_t;

endpackage

### rtl/deq_in_if.sv
// deq_in_if: request channel carrying one action and its value
// depends on deq_pkg

interface deq_in_if import deq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);

endinterface

### rtl/deq_out_if.sv
// deq_out_if: result channel carrying data, status, last and occupancy
// depends on deq_pkg

interface deq_out_if import deq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output data, output status, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input data, input status, input last,
                    input occupancy, output ready);

endinterface

### rtl/deq_cell.sv
// deq_cell: one entry of the queue chain, trades data with its neighbors
// depends on deq_pkg

module deq_cell import deq_pkg::*; (
    input  logic                     clk,
    input  cell_op_t                 op,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    input  logic signed [DATA_W-1:0] load_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // pick the next entry value
    always_comb
    begin
        case (op)
            CELL_SHIFT_LEFT:  data_next = right_data;
            CELL_SHIFT_RIGHT: data_next = left_data;
            CELL_LOAD:        data_next = load_data;
            default:          data_next = data_reg;
        endcase
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/double_ended_queue_unit.sv
// double_ended_queue_unit: bounded deque of signed 32-bit values on a chain of cells
// depends on deq_pkg, deq_in_if, deq_out_if and deq_cell
//
//  channel   | dir | payload                              | accepted when
//  in_chan   | in  | action[2:0], value[31:0]             | valid && ready
//  out_chan  | out | data[31:0], status, last, occupancy  | valid && ready
//
// push and pop each give one status result
// a readout gives one result per stored entry; the chain
// rotates one place per result and is back in order when the last entry has gone out
// a new request is taken only while no readout runs and the output register is free
// the output register holds a valid result while out_chan.ready is low; the chain holds with it
// reset (rst_n low, asynchronous) empties the queue; no clearing pass is needed

module double_ended_queue_unit import deq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    in_chan,
    deq_out_if.source out_chan
);

    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic [STAT_W-1:0]        out_status_reg, out_status_next;
    logic                     out_last_reg, out_last_next;
    logic [OCC_W-1:0]         out_occ_reg, out_occ_next;

    logic out_free;
    logic in_fire;
    logic is_full;
    logic is_empty;
    logic do_push_front;
    logic do_push_back;
    logic do_pop_front;
    logic do_rotate;
    logic rotate_last;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] load_data;
    cell_op_t                 cell_op   [DEPTH];

    // handshake
    assign out_free      = !out_valid_reg || out_chan.ready;
    assign in_chan.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = in_chan.valid && in_chan.ready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign do_push_front = in_fire && (in_chan.action == ACT_PUSH_FRONT) && !is_full;
    assign do_push_back  = in_fire && (in_chan.action == ACT_PUSH_BACK) && !is_full;
    assign do_pop_front  = in_fire && (in_chan.action == ACT_POP_FRONT) && !is_empty;
    assign do_rotate     = (state_reg == ST_READOUT) && out_free;
    assign rotate_last   = (CNT_W'(step_reg) + CNT_W'(1)) == count_reg;

    // readout wraps the head to the tail; push back loads the new tail
    assign load_data = (state_reg == ST_READOUT) ? cell_data[0] : in_chan.value;

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_head
            assign left_in = in_chan.value;
        end
        else
        begin : g_body
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_in = '0;
        end
        else
        begin : g_inner
            assign right_in = cell_data[i+1];
        end

        // per-cell command
        always_comb
        begin
            cell_op[i] = CELL_HOLD;
            if (do_push_front)
                cell_op[i] = CELL_SHIFT_RIGHT;
            else if (do_push_back && (count_reg == CNT_W'(i)))
                cell_op[i] = CELL_LOAD;
            else if (do_pop_front)
                cell_op[i] = CELL_SHIFT_LEFT;
            else if (do_rotate)
                cell_op[i] = (count_reg == CNT_W'(i + 1)) ? CELL_LOAD : CELL_SHIFT_LEFT;
        end

        deq_cell u_cell (
            .clk        (clk),
            .op         (cell_op[i]),
            .left_data  (left_in),
            .right_data (right_in),
            .load_data  (load_data),
            .data       (cell_data[i])
        );
    end

    // control and result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !out_chan.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_occ_next    = out_occ_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_data_next   = '0;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b1;
                    case (in_chan.action)
                        ACT_READ_ALL:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_READOUT;
                                step_next  = '0;
                            end
                        end
                        ACT_PUSH_FRONT, ACT_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                                out_status_next = STAT_FULL;
                            else
                                count_next = count_reg + CNT_W'(1);
                        end
                        ACT_POP_FRONT, ACT_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (is_empty)
                                out_status_next = STAT_EMPTY;
                            else
                                count_next = count_reg - CNT_W'(1);
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !out_chan.ready;
                        end
                    endcase
                    out_occ_next = OCC_W'(count_next);
                end
            end
            ST_READOUT:
            begin
                if (do_rotate)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = cell_data[0];
                    out_status_next = STAT_OK;
                    out_last_next   = rotate_last;
                    out_occ_next    = OCC_W'(count_reg);
                    if (rotate_last)
                    begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= STAT_OK;
            out_last_reg   <= 1'b0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign out_chan.valid     = out_valid_reg;
    assign out_chan.data      = out_data_reg;
    assign out_chan.status    = out_status_reg;
    assign out_chan.last      = out_last_reg;
    assign out_chan.occupancy = out_occ_reg;

    // count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // no request is taken during a readout
    a_no_accept_readout: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READOUT) |-> !in_chan.ready)
        else $error("request accepted during readout");

    // the count holds through a readout
    a_count_stable_readout: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READOUT) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed during readout");

    // the readout step stays inside the stored entries
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READOUT) |-> (CNT_W'(step_reg) < count_reg))
        else $error("readout step beyond stored entries");

endmodule
